>>> rtl/mks_pkg.sv
package mks_pkg;

    localparam int BUF_DEPTH = 16;
    localparam int PTR_W     = $clog2(BUF_DEPTH);

    localparam logic [23:0] DEBOUNCE_RESET = 24'd100000;
    localparam logic [15:0] SETTLE_RESET   = 16'd5;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    localparam logic [0:0] CFG_DEBOUNCE = 1'd0;
    localparam logic [0:0] CFG_SETTLE   = 1'd1;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_SETTLE   = 2'd2;

    // row-major, index {row, column}
    localparam logic [7:0] KEY_MAP [16] = '{
        8'h31, 8'h32, 8'h33, 8'h41,
        8'h34, 8'h35, 8'h36, 8'h42,
        8'h37, 8'h38, 8'h39, 8'h43,
        8'h2A, 8'h30, 8'h23, 8'h44
    };

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       flush;
        logic [7:0] code;
    } ring_cmd_t;

    typedef struct packed {
        logic       empty;
        logic [3:0] count;
        logic       drop;
    } ring_stat_t;

    typedef struct packed {
        logic       fire;
        logic [1:0] fire_col;
        logic [3:0] col_drive;
    } scan_stat_t;

    function automatic logic [7:0] key_ascii(input logic [1:0] row, input logic [1:0] col);
        return KEY_MAP[{row, col}];
    endfunction

endpackage

>>> rtl/mks_ring.sv
module mks_ring (
    input  logic               clk,
    input  logic               rst_n,
    input  mks_pkg::ring_cmd_t cmd,
    output logic [7:0]         rd_data,
    output mks_pkg::ring_stat_t stat
);
    import mks_pkg::*;

    localparam int CNT_W = PTR_W + 5;

    logic [7:0]       key_store [BUF_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_inc;
    logic [PTR_W-1:0] wr_inc;
    logic [CNT_W-1:0] cnt_raw;
    logic [CNT_W-1:0] cnt_mod;
    logic             full_hit;

    assign rd_inc   = (rd_ptr_reg == PTR_W'(BUF_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign wr_inc   = (wr_ptr_reg == PTR_W'(BUF_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign full_hit = (wr_ptr_reg == rd_ptr_reg);

    // count lies below twice the depth, one subtract folds it back
    assign cnt_raw = CNT_W'(wr_ptr_reg) + CNT_W'(BUF_DEPTH) - CNT_W'(rd_ptr_reg) - CNT_W'(1);
    assign cnt_mod = (cnt_raw >= CNT_W'(BUF_DEPTH)) ? cnt_raw - CNT_W'(BUF_DEPTH) : cnt_raw;

    assign stat.empty = (rd_inc == wr_ptr_reg);
    assign stat.count = cnt_mod[3:0];
    assign stat.drop  = cmd.push && full_hit;
    assign rd_data    = rd_data_reg;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (cmd.flush)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = PTR_W'(1);
        end
        else if (cmd.push)
        begin
            wr_ptr_next = wr_inc;
            if (full_hit)
            begin
                rd_ptr_next = rd_inc;
            end
        end
        else if (cmd.pop && !stat.empty)
        begin
            rd_ptr_next = rd_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= PTR_W'(1);
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && !cmd.flush)
        begin
            key_store[wr_ptr_reg] <= cmd.code;
        end
        if (cmd.pop)
        begin
            rd_data_reg <= key_store[rd_inc];
        end
    end

endmodule

>>> rtl/mks_scan.sv
module mks_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick,
    input  logic [3:0]          rows,
    input  logic [23:0]         debounce_ticks,
    input  logic [15:0]         settle_ticks,
    output mks_pkg::scan_stat_t stat
);
    import mks_pkg::*;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [23:0] timer_reg;
    logic [23:0] timer_next;
    logic [1:0]  col_reg;
    logic [1:0]  col_next;
    logic [1:0]  trig_reg;
    logic [1:0]  trig_next;
    logic [3:0]  prev_reg;
    logic [23:0] timer_dec;
    logic [23:0] debounce_load;
    logic [23:0] settle_load;
    logic [3:0]  falling;
    logic [1:0]  first_fall;
    logic        expired;

    // the one decrementer shared by the debounce and settle waits
    assign timer_dec     = timer_reg - 24'd1;
    assign expired       = (timer_dec == '0);
    assign debounce_load = (debounce_ticks == '0) ? 24'd1 : debounce_ticks;
    assign settle_load   = (settle_ticks == '0) ? 24'd1 : {8'd0, settle_ticks};
    assign falling       = prev_reg & ~rows;

    always_comb
    begin
        if (falling[0])
        begin
            first_fall = 2'd0;
        end
        else if (falling[1])
        begin
            first_fall = 2'd1;
        end
        else if (falling[2])
        begin
            first_fall = 2'd2;
        end
        else
        begin
            first_fall = 2'd3;
        end
    end

    assign stat.fire      = (phase_reg == PH_SETTLE) && expired;
    assign stat.fire_col  = col_reg;
    assign stat.col_drive = (phase_reg == PH_SETTLE) ? ~(4'b0001 << col_reg) : 4'b0000;

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        col_next   = col_reg;
        trig_next  = trig_reg;
        unique case (phase_reg)
            PH_DEBOUNCE:
            begin
                timer_next = timer_dec;
                if (expired)
                begin
                    if (!rows[trig_reg])
                    begin
                        col_next   = 2'd0;
                        timer_next = settle_load;
                        phase_next = PH_SETTLE;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_SETTLE:
            begin
                timer_next = timer_dec;
                if (expired)
                begin
                    if (col_reg == 2'd3)
                    begin
                        col_next   = 2'd0;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + 2'd1;
                        timer_next = settle_load;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (falling != 4'd0)
                begin
                    trig_next  = first_fall;
                    timer_next = debounce_load;
                    phase_next = PH_DEBOUNCE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            col_reg   <= '0;
            trig_reg  <= '0;
            prev_reg  <= 4'hF;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            col_reg   <= col_next;
            trig_reg  <= trig_next;
            prev_reg  <= rows;
        end
    end

endmodule

>>> rtl/matrix_keypad_scanner_fifo_core.sv
// channel  | handshake             | payload
// in       | in_valid / in_ready   | action, row_lines
// out      | out_valid / out_ready | column_drive, key_valid, key_code,
//          |                       | buffer_empty, key_count, dropped
// cfg      | cfg_write             | cfg_index, cfg_data
//
// a tick goes to the done state, through the push state if a column sample
// fires: the ring has one write port, so the four rows are pushed one a cycle
// a pop that finds a key passes the read state (registered key store read),
// a flush goes to done; a new item is taken while the previous result waits
// in the output register; an item's final cycle holds until it is free
// reset is asynchronous and needs no clearing pass
module matrix_keypad_scanner_fifo_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [3:0] row_lines,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] column_drive,
    output logic       key_valid,
    output logic [7:0] key_code,
    output logic       buffer_empty,
    output logic [3:0] key_count,
    output logic       dropped,
    input  logic       cfg_write,
    input  logic [0:0] cfg_index,
    input  logic [23:0] cfg_data
);
    import mks_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [23:0] debounce_reg;
    logic [15:0] settle_reg;
    logic [3:0]  push_rows_reg;
    logic [1:0]  push_col_reg;
    logic [1:0]  row_idx_reg;
    logic        drop_acc_reg;
    logic        kv_reg;
    logic [7:0]  code_reg;
    logic        out_valid_reg;
    logic [3:0]  column_drive_reg;
    logic        key_valid_reg;
    logic [7:0]  key_code_reg;
    logic        buffer_empty_reg;
    logic [3:0]  key_count_reg;
    logic        dropped_reg;
    logic        accept;
    logic        tick;
    logic        out_load;
    ring_cmd_t   ring_cmd;
    ring_stat_t  ring_stat;
    logic [7:0]  ring_rd;
    scan_stat_t  scan_stat;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign tick     = accept && (action == ACT_TICK);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    mks_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .rows           (row_lines),
        .debounce_ticks (debounce_reg),
        .settle_ticks   (settle_reg),
        .stat           (scan_stat)
    );

    mks_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ring_cmd),
        .rd_data (ring_rd),
        .stat    (ring_stat)
    );

    always_comb
    begin
        ring_cmd.push  = (state_reg == ST_PUSH) && !push_rows_reg[row_idx_reg];
        ring_cmd.pop   = accept && (action == ACT_POP);
        ring_cmd.flush = accept && (action == ACT_FLUSH);
        ring_cmd.code  = key_ascii(row_idx_reg, push_col_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (tick && scan_stat.fire)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if ((action == ACT_POP) && !ring_stat.empty)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PUSH:
            begin
                if (row_idx_reg == 2'd3)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            debounce_reg  <= DEBOUNCE_RESET;
            settle_reg    <= SETTLE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_DEBOUNCE: debounce_reg <= cfg_data;
                    CFG_SETTLE:   settle_reg   <= cfg_data[15:0];
                    default:      settle_reg   <= settle_reg;
                endcase
            end
        end
    end

    // working item and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            push_rows_reg <= row_lines;
            push_col_reg  <= scan_stat.fire_col;
            row_idx_reg   <= 2'd0;
            drop_acc_reg  <= 1'b0;
            kv_reg        <= (action == ACT_POP) && !ring_stat.empty;
            code_reg      <= 8'd0;
        end
        if (state_reg == ST_PUSH)
        begin
            row_idx_reg  <= row_idx_reg + 2'd1;
            drop_acc_reg <= drop_acc_reg | ring_stat.drop;
        end
        if (state_reg == ST_READ)
        begin
            code_reg <= ring_rd;
        end
        if (out_load)
        begin
            column_drive_reg <= scan_stat.col_drive;
            key_valid_reg    <= kv_reg;
            key_code_reg     <= code_reg;
            buffer_empty_reg <= ring_stat.empty;
            key_count_reg    <= ring_stat.count;
            dropped_reg      <= drop_acc_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_drive = column_drive_reg;
    assign key_valid    = key_valid_reg;
    assign key_code     = key_code_reg;
    assign buffer_empty = buffer_empty_reg;
    assign key_count    = key_count_reg;
    assign dropped      = dropped_reg;

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("item accepted on the cycle after another");

    a_no_code_without_key: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !key_valid) |-> (key_code == 8'd0))
        else $error("key code without a popped key");

    a_single_column: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((column_drive == 4'b0000) || ($countones(~column_drive) == 1)))
        else $error("more than one column driven low in a scan");

    a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (buffer_empty == (key_count == 4'd0)))
        else $error("empty flag disagrees with key count");

    a_push_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> (out_load == 1'b0))
        else $error("result loaded while keys are being pushed");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    import mks_pkg::*;

    typedef struct packed {
        logic [3:0] column_drive;
        logic       key_valid;
        logic [7:0] key_code;
        logic       buffer_empty;
        logic [3:0] key_count;
        logic       dropped;
    } keypad_status_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [3:0]  row_lines;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  column_drive;
    logic        key_valid;
    logic [7:0]  key_code;
    logic        buffer_empty;
    logic [3:0]  key_count;
    logic        dropped;
    logic        cfg_write;
    logic [0:0]  cfg_index;
    logic [23:0] cfg_data;

    // scanner and ring copy
    logic [23:0]      debounce_len;
    logic [15:0]      settle_len;
    logic [1:0]       scan_phase;
    logic [23:0]      wait_left;
    logic [1:0]       scan_col;
    logic [1:0]       trig_row;
    logic [3:0]       last_rows;
    logic [7:0]       key_ring [BUF_DEPTH];
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] wr_ptr;
    string            key_layout = "123A456B789C*0#D";

    keypad_status_t status_due[$];
    int             mismatches = 0;
    int             items_sent = 0;
    int             send_idle_pct = 0;
    int             ready_stall_pct = 0;
    int             hold_left = 0;

    matrix_keypad_scanner_fifo_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .row_lines    (row_lines),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .column_drive (column_drive),
        .key_valid    (key_valid),
        .key_code     (key_code),
        .buffer_empty (buffer_empty),
        .key_count    (key_count),
        .dropped      (dropped),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [23:0] at_least_one(input logic [23:0] v);
        return (v == 24'd0) ? 24'd1 : v;
    endfunction

    function automatic logic ring_is_empty();
        logic [PTR_W-1:0] nxt;
        nxt = rd_ptr + 1'b1;
        return nxt == wr_ptr;
    endfunction

    function automatic logic [3:0] drive_now();
        return (scan_phase == PH_SETTLE) ? ~(4'b0001 << scan_col) : 4'b0000;
    endfunction

    // rows seen with the given keys held and the columns as currently driven
    function automatic logic [3:0] rows_for(input logic [15:0] held, input logic [3:0] cols);
        logic [3:0] rows;
        rows = 4'hF;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (held[r*4+c] && !cols[c])
                    rows[r] = 1'b0;
        return rows;
    endfunction

    function automatic keypad_status_t step_keypad(input logic [1:0] act, input logic [3:0] rows);
        keypad_status_t   res;
        logic [3:0]       falling;
        logic [PTR_W-1:0] nxt;
        res = '0;
        case (act)
            ACT_TICK:
            begin
                if (scan_phase == PH_IDLE)
                begin
                    falling = last_rows & ~rows;
                    if (falling != 4'd0)
                    begin
                        for (int r = 3; r >= 0; r--)
                            if (falling[r])
                                trig_row = r[1:0];
                        wait_left = at_least_one(debounce_len);
                        scan_phase = PH_DEBOUNCE;
                    end
                end
                else if (scan_phase == PH_DEBOUNCE)
                begin
                    wait_left = wait_left - 1'b1;
                    if (wait_left == 24'd0)
                    begin
                        if (!rows[trig_row])
                        begin
                            scan_col = 2'd0;
                            wait_left = at_least_one({8'd0, settle_len});
                            scan_phase = PH_SETTLE;
                        end
                        else
                            scan_phase = PH_IDLE;
                    end
                end
                else
                begin
                    wait_left = wait_left - 1'b1;
                    if (wait_left == 24'd0)
                    begin
                        for (int r = 0; r < 4; r++)
                            if (!rows[r])
                            begin
                                key_ring[wr_ptr] = key_layout[r*4 + scan_col];
                                if (wr_ptr == rd_ptr)
                                begin
                                    rd_ptr = rd_ptr + 1'b1;
                                    res.dropped = 1'b1;
                                end
                                wr_ptr = wr_ptr + 1'b1;
                            end
                        if (scan_col == 2'd3)
                        begin
                            scan_col = 2'd0;
                            scan_phase = PH_IDLE;
                        end
                        else
                        begin
                            scan_col = scan_col + 1'b1;
                            wait_left = at_least_one({8'd0, settle_len});
                        end
                    end
                end
                last_rows = rows;
            end
            ACT_POP:
            begin
                if (!ring_is_empty())
                begin
                    rd_ptr = rd_ptr + 1'b1;
                    res.key_code = key_ring[rd_ptr];
                    res.key_valid = 1'b1;
                end
            end
            ACT_FLUSH:
            begin
                rd_ptr = '0;
                wr_ptr = PTR_W'(1);
            end
            default: ;
        endcase
        res.column_drive = drive_now();
        res.buffer_empty = ring_is_empty();
        nxt = wr_ptr - rd_ptr - 1'b1;
        res.key_count = nxt;
        return res;
    endfunction

    function automatic void match_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_status
        keypad_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (status_due.size() == 0)
            begin
                $display("%0t unexpected item: expected none actual %0h/%0h/%0h/%0h/%0h/%0h",
                         $time, column_drive, key_valid, key_code, buffer_empty,
                         key_count, dropped);
                mismatches++;
            end
            else
            begin
                want = status_due.pop_front();
                match_field("column_drive", want.column_drive, column_drive);
                match_field("key_valid", want.key_valid, key_valid);
                match_field("key_code", want.key_code, key_code);
                match_field("buffer_empty", want.buffer_empty, buffer_empty);
                match_field("key_count", want.key_count, key_count);
                match_field("dropped", want.dropped, dropped);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [3:0] rows);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        row_lines <= rows;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        status_due.push_back(step_keypad(act, rows));
        items_sent++;
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic [0:0] idx, input logic [23:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_DEBOUNCE)
            debounce_len = data;
        else
            settle_len = data[15:0];
    endtask

    task automatic test_reset_status();
        send_item(ACT_POP, 4'hF);
        send_item(ACT_FLUSH, 4'h0);
        send_item(ACT_TICK, 4'hF);
    endtask

    // zero waits act as one; all rows fall at once so row 0 triggers
    task automatic test_zero_waits_all_rows();
        settle_block();
        write_register(CFG_DEBOUNCE, 24'd0);
        write_register(CFG_SETTLE, 24'hA50000);
        repeat (6) send_item(ACT_TICK, 4'b0000);
        send_item(ACT_POP, 4'hA);
        send_item(ACT_POP, 4'h5);
        send_item(ACT_FLUSH, 4'hF);
        send_item(ACT_POP, 4'h0);
    endtask

    task automatic test_bounce_reject();
        send_item(ACT_TICK, 4'b1111);
        send_item(ACT_TICK, 4'b1011);
        send_item(ACT_TICK, 4'b1111);
    endtask

    // falling edges during a scan are ignored, a held key does not retrigger
    task automatic test_edges_during_scan();
        send_item(ACT_TICK, 4'b1011);
        send_item(ACT_TICK, 4'b1011);
        send_item(ACT_TICK, 4'b0111);
        send_item(ACT_TICK, 4'b0011);
        send_item(ACT_TICK, 4'b1111);
        send_item(ACT_TICK, 4'b1110);
        send_item(ACT_TICK, 4'b1110);
        send_item(ACT_POP, 4'h3);
        send_item(ACT_POP, 4'hC);
    endtask

    task automatic press_keys();
        logic [15:0] held;
        int          span;
        bit          started;
        held = 16'd0;
        if ($urandom_range(9) == 0)
            held = 16'($urandom_range(16'hFFFF, 1));
        else
        begin
            held[$urandom_range(15)] = 1'b1;
            if ($urandom_range(2) == 0)
                held[$urandom_range(15)] = 1'b1;
        end
        repeat ($urandom_range(2)) send_item(ACT_TICK, 4'($urandom_range(15)));
        if ($urandom_range(99) < 15)
            span = $urandom_range(debounce_len, 1);
        else
            span = debounce_len + 4 * settle_len + 3;
        started = 0;
        for (int i = 0; i < span; i++)
        begin
            if ($urandom_range(9) == 0)
                send_item(ACT_POP, 4'($urandom_range(15)));
            send_item(ACT_TICK, rows_for(held, drive_now()));
            if (scan_phase != PH_IDLE)
                started = 1;
            else if (started)
                break;
        end
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(3, 1)) send_item(ACT_TICK, rows_for(held, drive_now()));
        repeat ($urandom_range(2, 1)) send_item(ACT_TICK, 4'hF);
        repeat ($urandom_range(4)) send_item(ACT_POP, 4'($urandom_range(15)));
        if ($urandom_range(19) == 0)
            send_item(ACT_FLUSH, 4'($urandom_range(15)));
    endtask

    task automatic test_random_keys(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 75)
                press_keys();
            else
                repeat ($urandom_range(4, 1))
                    send_item(2'($urandom_range(2)), 4'($urandom_range(15)));
        end
    endtask

    task automatic test_backpressure();
        settle_block();
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        hold_left       = 300;
        repeat (60) send_item(2'($urandom_range(2)), 4'($urandom_range(15)));
    endtask

    // largest waits: a debounce is started but never runs out
    task automatic test_wait_extremes();
        settle_block();
        write_register(CFG_SETTLE, {8'($urandom_range(255)), 16'hFFFF});
        write_register(CFG_DEBOUNCE, 24'hFFFFFF);
        repeat (12)
            send_item(2'($urandom_range(2)), 4'hF);
        send_item(ACT_TICK, 4'b0111);
        repeat (6)
            send_item(2'($urandom_range(2)), 4'($urandom_range(15)));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_TICK;
        row_lines = 4'hF;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_DEBOUNCE;
        cfg_data  = 24'd0;

        debounce_len = DEBOUNCE_RESET;
        settle_len   = SETTLE_RESET;
        scan_phase   = PH_IDLE;
        wait_left    = 24'd0;
        scan_col     = 2'd0;
        trig_row     = 2'd0;
        last_rows    = 4'hF;
        rd_ptr       = '0;
        wr_ptr       = PTR_W'(1);
        for (int i = 0; i < BUF_DEPTH; i++)
            key_ring[i] = 8'd0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_status();
        test_zero_waits_all_rows();
        test_bounce_reject();
        test_edges_during_scan();

        for (int p = 0; p < 4; p++)
        begin
            settle_block();
            write_register(CFG_DEBOUNCE, (p == 0) ? 24'd1 : 24'($urandom_range(8, 2)));
            write_register(CFG_SETTLE, {8'($urandom_range(255)),
                                        (p == 0) ? 16'd1 : 16'($urandom_range(4, 1))});
            send_idle_pct   = (p == 1) ? 74 : (p == 3) ? 14 : 0;
            ready_stall_pct = (p == 2) ? 74 : (p == 3) ? 14 : 0;
            test_random_keys(340);
        end

        test_backpressure();
        test_wait_extremes();

        settle_block();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
